// ===== rtl/core/dghsv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dghsv_pkg;

   localparam int HSV_SHIFT = 12;
   localparam int S_SCALE   = 255 << HSV_SHIFT;
   localparam int H_SCALE   = 180 << HSV_SHIFT;
   localparam int H_WRAP    = 180;

   localparam logic [5:0] HEIGHT_THRESHOLD_RESET   = 6'd10;
   localparam logic [6:0] DISTANCE_THRESHOLD_RESET = 7'd10;

   localparam logic [7:0] CSR_HEIGHT_THRESHOLD   = 8'd0;
   localparam logic [7:0] CSR_DISTANCE_THRESHOLD = 8'd1;

   localparam logic [8:0] S_MIN = 9'd200;
   localparam logic [7:0] V_MIN = 8'd30;

   localparam logic [7:0] BLUE_H_LO   = 8'd110;
   localparam logic [7:0] BLUE_H_HI   = 8'd130;
   localparam logic [7:0] GREEN_H_LO  = 8'd50;
   localparam logic [7:0] GREEN_H_HI  = 8'd70;
   localparam logic [7:0] RED_H_HI    = 8'd10;
   localparam logic [7:0] YELLOW_H_LO = 8'd25;
   localparam logic [7:0] YELLOW_H_HI = 8'd35;

   localparam logic [2:0] CLASS_NONE   = 3'd0;
   localparam logic [2:0] CLASS_BLUE   = 3'd1;
   localparam logic [2:0] CLASS_GREEN  = 3'd2;
   localparam logic [2:0] CLASS_RED    = 3'd3;
   localparam logic [2:0] CLASS_YELLOW = 3'd4;

   typedef struct packed {
      logic [7:0]         pixel_blue;
      logic [7:0]         pixel_green;
      logic [7:0]         pixel_red;
      logic [15:0]        camera_depth_mm;
      logic               depth_invalid;
      logic signed [15:0] robot_height_mm;
   } req_type;

   typedef struct packed {
      logic       is_background;
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       is_object;
      logic [2:0] color_class;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/depth_gated_hsv_color_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                   handshake
// request   start, busy, req_data                   taken when start && !busy
// response  rsp_strobe, rsp_data                    one cycle per result, no backpressure
// config    csr_valid, csr_ready, csr_index, csr_wdata  written when valid && ready
//
// one request per clock while busy is low; each response passes the stage 1, 2, 3 and output registers
// the pipeline steps, in order: gating and max/min, reciprocal lookup,
// multiply, rounding and box test
// reset clears the valid bits, loads the threshold defaults and holds busy high
// the receiver cannot stall, so the pipeline never stops

module depth_gated_hsv_color_classifier (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire dghsv_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output dghsv_pkg::rsp_type     rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_index,
   input  wire logic [7:0]        csr_wdata
);

   // configuration
   logic [5:0]  height_thr_ff;
   logic [6:0]  dist_thr_ff;
   logic        busy_ff;

   // stage 0 logic
   logic        bg_in;
   logic [10:0] depth_limit;
   logic [7:0]  b_in, g_in, r_in, v_in, vmin_in;

   // stage 1 registers
   logic        valid1_ff;
   logic        bg1_ff;
   logic [7:0]  b1_ff, g1_ff, r1_ff, v1_ff, vmin1_ff;
   logic        sel_r1_ff, sel_g1_ff;

   logic [7:0]  diff1;
   logic signed [11:0] hnum_in;

   // stage 2 registers
   logic        valid2_ff;
   logic        bg2_ff;
   logic [7:0]  b2_ff, g2_ff, r2_ff, v2_ff, diff2_ff;
   logic [19:0] sdiv2_ff;
   logic [16:0] hdiv2_ff;
   logic signed [11:0] hnum2_ff;

   // stage 3 registers
   logic        valid3_ff;
   logic        bg3_ff;
   logic [7:0]  b3_ff, g3_ff, r3_ff, v3_ff;
   logic [27:0] sprod3_ff;
   logic signed [29:0] hprod3_ff;

   logic [27:0] s_sum;
   logic [8:0]  s_val;
   logic signed [29:0] h_sum;
   logic signed [9:0]  h_raw;
   logic [9:0]  h_wrapped;
   logic [7:0]  h_val;
   logic [2:0]  class_in;

   // output registers
   logic        valid4_ff;
   dghsv_pkg::rsp_type rsp_ff;

   // reciprocal tables, built at elaboration
   logic [19:0] sdiv_lut [256];
   logic [16:0] hdiv_lut [256];

   for (genvar idx = 0; idx < 256; idx++) begin : g_lut
      localparam int SD   = (idx == 0) ? 1 : idx;
      localparam int SQ   = dghsv_pkg::S_SCALE / SD;
      localparam int SR   = dghsv_pkg::S_SCALE % SD;
      localparam int SRND = SQ + (((2 * SR > SD) || ((2 * SR == SD) && (SQ % 2 == 1))) ? 1 : 0);
      localparam int HD   = 6 * SD;
      localparam int HQ   = dghsv_pkg::H_SCALE / HD;
      localparam int HR   = dghsv_pkg::H_SCALE % HD;
      localparam int HRND = HQ + (((2 * HR > HD) || ((2 * HR == HD) && (HQ % 2 == 1))) ? 1 : 0);
      assign sdiv_lut[idx] = (idx == 0) ? 20'd0 : 20'(SRND);
      assign hdiv_lut[idx] = (idx == 0) ? 17'd0 : 17'(HRND);
   end

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_thr_ff <= dghsv_pkg::HEIGHT_THRESHOLD_RESET;
         dist_thr_ff   <= dghsv_pkg::DISTANCE_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dghsv_pkg::CSR_HEIGHT_THRESHOLD: begin
               height_thr_ff <= csr_wdata[5:0];
            end
            dghsv_pkg::CSR_DISTANCE_THRESHOLD: begin
               dist_thr_ff <= csr_wdata[6:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // stage 0: depth gating, masking, max and min
   always_comb begin
      depth_limit = {1'b0, dist_thr_ff, 3'b000} + {3'b000, dist_thr_ff, 1'b0};
      bg_in = (req_data.robot_height_mm < $signed({10'd0, height_thr_ff}))
              || (req_data.camera_depth_mm < {5'd0, depth_limit})
              || req_data.depth_invalid;
      b_in = bg_in ? 8'd0 : req_data.pixel_blue;
      g_in = bg_in ? 8'd0 : req_data.pixel_green;
      r_in = bg_in ? 8'd0 : req_data.pixel_red;
      v_in = b_in;
      if (g_in > v_in) v_in = g_in;
      if (r_in > v_in) v_in = r_in;
      vmin_in = b_in;
      if (g_in < vmin_in) vmin_in = g_in;
      if (r_in < vmin_in) vmin_in = r_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= start && !busy_ff;
      end
      bg1_ff    <= bg_in;
      b1_ff     <= b_in;
      g1_ff     <= g_in;
      r1_ff     <= r_in;
      v1_ff     <= v_in;
      vmin1_ff  <= vmin_in;
      sel_r1_ff <= (v_in == r_in);
      sel_g1_ff <= (v_in == g_in);
   end

   // stage 1: spread, hue numerator, reciprocal lookup
   always_comb begin
      diff1 = v1_ff - vmin1_ff;
      if (sel_r1_ff) begin
         hnum_in = $signed({4'd0, g1_ff}) - $signed({4'd0, b1_ff});
      end else if (sel_g1_ff) begin
         hnum_in = $signed({4'd0, b1_ff}) - $signed({4'd0, r1_ff})
                   + $signed({3'd0, diff1, 1'b0});
      end else begin
         hnum_in = $signed({4'd0, r1_ff}) - $signed({4'd0, g1_ff})
                   + $signed({2'd0, diff1, 2'b00});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      bg2_ff   <= bg1_ff;
      b2_ff    <= b1_ff;
      g2_ff    <= g1_ff;
      r2_ff    <= r1_ff;
      v2_ff    <= v1_ff;
      diff2_ff <= diff1;
      sdiv2_ff <= sdiv_lut[v1_ff];
      hdiv2_ff <= hdiv_lut[diff1];
      hnum2_ff <= hnum_in;
   end

   // stage 2: multiplies
   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
      bg3_ff    <= bg2_ff;
      b3_ff     <= b2_ff;
      g3_ff     <= g2_ff;
      r3_ff     <= r2_ff;
      v3_ff     <= v2_ff;
      sprod3_ff <= {20'd0, diff2_ff} * {8'd0, sdiv2_ff};
      hprod3_ff <= 30'(hnum2_ff) * $signed({13'd0, hdiv2_ff});
   end

   // stage 3: rounding, hue wrap, box test
   always_comb begin
      s_sum     = sprod3_ff + 28'(1 << (dghsv_pkg::HSV_SHIFT - 1));
      s_val     = s_sum[20:12];
      h_sum     = hprod3_ff + 30'(1 << (dghsv_pkg::HSV_SHIFT - 1));
      h_raw     = h_sum[21:12];
      h_wrapped = h_raw[9] ? (h_raw + 10'(dghsv_pkg::H_WRAP)) : h_raw;
      h_val     = h_wrapped[7:0];
      class_in  = dghsv_pkg::CLASS_NONE;
      if ((s_sum[27:21] == 7'd0) && (s_val >= dghsv_pkg::S_MIN)
          && (v3_ff >= dghsv_pkg::V_MIN)) begin
         if ((h_val >= dghsv_pkg::BLUE_H_LO) && (h_val <= dghsv_pkg::BLUE_H_HI)) begin
            class_in = dghsv_pkg::CLASS_BLUE;
         end else if ((h_val >= dghsv_pkg::GREEN_H_LO)
                      && (h_val <= dghsv_pkg::GREEN_H_HI)) begin
            class_in = dghsv_pkg::CLASS_GREEN;
         end else if (h_val <= dghsv_pkg::RED_H_HI) begin
            class_in = dghsv_pkg::CLASS_RED;
         end else if ((h_val >= dghsv_pkg::YELLOW_H_LO)
                      && (h_val <= dghsv_pkg::YELLOW_H_HI)) begin
            class_in = dghsv_pkg::CLASS_YELLOW;
         end
      end
      // saturated s above the 9-bit field still passes the test
      if ((s_sum[27:21] != 7'd0) && (v3_ff >= dghsv_pkg::V_MIN)) begin
         if ((h_val >= dghsv_pkg::BLUE_H_LO) && (h_val <= dghsv_pkg::BLUE_H_HI)) begin
            class_in = dghsv_pkg::CLASS_BLUE;
         end else if ((h_val >= dghsv_pkg::GREEN_H_LO)
                      && (h_val <= dghsv_pkg::GREEN_H_HI)) begin
            class_in = dghsv_pkg::CLASS_GREEN;
         end else if (h_val <= dghsv_pkg::RED_H_HI) begin
            class_in = dghsv_pkg::CLASS_RED;
         end else if ((h_val >= dghsv_pkg::YELLOW_H_LO)
                      && (h_val <= dghsv_pkg::YELLOW_H_HI)) begin
            class_in = dghsv_pkg::CLASS_YELLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= valid3_ff;
      end
      rsp_ff.is_background <= bg3_ff;
      rsp_ff.out_blue      <= b3_ff;
      rsp_ff.out_green     <= g3_ff;
      rsp_ff.out_red       <= r3_ff;
      rsp_ff.is_object     <= (class_in != dghsv_pkg::CLASS_NONE);
      rsp_ff.color_class   <= class_in;
   end

   assign rsp_strobe = valid4_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire
